### hw/rtl/assert_macros.svh
// Assertion helpers, clocked on the rising edge, off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  `ASSERT_AT(lbl, clk, rst, (ante) |-> (cons), msg)

`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  `ASSERT_AT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

### hw/rtl/qbb_pkg.sv
package qbb_pkg;

  localparam int CELL_LIMIT = 127;
  localparam int PAD_Q16    = 3277;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int STAGES     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z  = 3'd5;

  localparam logic [31:0] CENTER_RST = 32'd258;
  localparam logic [31:0] SCALE_RST  = 32'h7F00_0000;

  localparam logic signed [7:0] CELL_HI  = 8'(CELL_LIMIT);
  localparam logic signed [7:0] CELL_LO  = 8'(-CELL_LIMIT);
  localparam logic signed [7:0] WORLD_LO = 8'(-(CELL_LIMIT + 1));

  typedef enum logic [1:0] {
    CMD_BOX    = 2'd0,
    CMD_SPHERE = 2'd1,
    CMD_RAY    = 2'd2,
    CMD_WORLD  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [30:0]        radius;
    logic signed [31:0] start_t;
    logic signed [31:0] end_t;
    logic               use_start;
    logic               use_end;
  } qbb_prim_t;

  typedef struct packed {
    logic signed [7:0] cell_xmin;
    logic signed [7:0] cell_ymin;
    logic signed [7:0] cell_zmin;
    logic signed [7:0] cell_xmax;
    logic signed [7:0] cell_ymax;
    logic signed [7:0] cell_zmax;
  } qbb_bound_t;

  typedef struct packed {
    logic diff;
    logic mul;
    logic clamp;
  } qbb_qen_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33(33'(a) + 33'(b));
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat33(33'(a) - 33'(b));
  endfunction

  // Q32.32 product back to Q16.16, toward zero, saturated
  function automatic logic signed [31:0] trunc_q16(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    adj = adj >>> 16;
    if (adj > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (adj < -64'sh0000_0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return adj[31:0];
  endfunction

endpackage

### hw/rtl/qbb_prim_if.sv
interface qbb_prim_if;
  import qbb_pkg::*;

  logic      valid;
  logic      ready;
  qbb_prim_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/qbb_bound_if.sv
interface qbb_bound_if;
  import qbb_pkg::*;

  logic       valid;
  logic       ready;
  qbb_bound_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/qbb_quant.sv
module qbb_quant (
  input  logic               clk,
  input  qbb_pkg::qbb_qen_t  en,
  input  logic signed [31:0] coord,
  input  logic signed [31:0] center,
  input  logic [31:0]        scale,
  output logic signed [7:0]  qcell
);
  import qbb_pkg::*;

  localparam logic signed [64:0] RND = (65'sd1 <<< 40) - 65'sd1;
  localparam logic signed [64:0] LIM = 65'(CELL_LIMIT);

  logic signed [31:0] d;
  logic signed [64:0] prod;
  logic signed [64:0] adj;
  logic signed [64:0] q;
  logic signed [7:0]  qcell_next;

  always_comb begin
    adj = prod + (prod[64] ? RND : 65'sd0);
    q   = adj >>> 40;
    if (q > LIM) begin
      qcell_next = CELL_HI;
    end else if (q < -LIM) begin
      qcell_next = CELL_LO;
    end else begin
      qcell_next = q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.diff) begin
      d <= sat_sub(coord, center);
    end
    if (en.mul) begin
      prod <= 65'(d) * 65'($signed({1'b0, scale}));
    end
    if (en.clamp) begin
      qcell <= qcell_next;
    end
  end

endmodule

### hw/rtl/quantized_bound_box.sv
// Quantized axis-aligned bound of one primitive per item (box/line, sphere, ray or
// whole world). Fully pipelined: a new item is accepted every cycle unless a stalled
// output has backed up the pipe, and it passes nine register stages (inputs, ray
// multiply, Q16.16 truncation, start point, end point, center subtract, scale
// multiply, cell clamp, min/max output register). Each stage holds its own valid
// bit and advances while the next stage has room, so a stalled output fills the
// pipe before the input stops. Center and scale registers reset to 258 and 127.0;
// write them only while no item is in flight.
module quantized_bound_box (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qbb_pkg::CFG_W-1:0]       cfg_data,
  qbb_prim_if.sink                        prim,
  qbb_bound_if.source                     bound
);
  import qbb_pkg::*;

  logic [31:0] ctr [3];
  logic [31:0] scl [3];

  logic [STAGES:1]   v;
  logic [STAGES+1:1] en;

  // stage 1
  logic [1:0]         s1_cmd;
  logic signed [31:0] s1_a [3];
  logic signed [31:0] s1_b [3];
  logic signed [31:0] s1_r;
  logic signed [31:0] s1_t0;
  logic signed [31:0] s1_len;
  logic               s1_us;
  logic               s1_ue;
  // stage 2
  logic [1:0]         s2_cmd;
  logic signed [31:0] s2_a [3];
  logic signed [31:0] s2_b [3];
  logic signed [63:0] s2_pm0 [3];
  logic signed [63:0] s2_pm1 [3];
  logic signed [31:0] s2_lo [3];
  logic signed [31:0] s2_hi [3];
  logic               s2_us;
  logic               s2_ue;
  // stage 3
  logic [1:0]         s3_cmd;
  logic signed [31:0] s3_a [3];
  logic signed [31:0] s3_b [3];
  logic signed [31:0] s3_m0 [3];
  logic signed [31:0] s3_m1 [3];
  logic signed [31:0] s3_lo [3];
  logic signed [31:0] s3_hi [3];
  logic               s3_us;
  logic               s3_ue;
  // stage 4
  logic [1:0]         s4_cmd;
  logic signed [31:0] s4_p1 [3];
  logic signed [31:0] s4_step [3];
  // stage 5
  logic [1:0]         s5_cmd;
  logic signed [31:0] s5_pt [2][3];
  // stages 6..8
  logic [1:0]         s6_cmd;
  logic [1:0]         s7_cmd;
  logic [1:0]         s8_cmd;
  logic signed [7:0]  qc [2][3];
  logic signed [7:0]  cmin [3];
  logic signed [7:0]  cmax [3];

  qbb_qen_t qen;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ctr[i] <= CENTER_RST;
        scl[i] <= SCALE_RST;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: ctr[0] <= cfg_data;
        REG_CENTER_Y: ctr[1] <= cfg_data;
        REG_CENTER_Z: ctr[2] <= cfg_data;
        REG_SCALE_X:  scl[0] <= cfg_data;
        REG_SCALE_Y:  scl[1] <= cfg_data;
        REG_SCALE_Z:  scl[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage k loads when it is empty or its content moves on
  always_comb begin
    en[STAGES+1] = !bound.valid || bound.ready;
    for (int k = STAGES; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign prim.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v           <= '0;
      bound.valid <= 1'b0;
    end else begin
      if (en[1]) begin
        v[1] <= prim.valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (en[STAGES+1]) begin
        bound.valid <= v[STAGES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_cmd  <= prim.data.command;
      s1_a[0] <= prim.data.first_x;
      s1_a[1] <= prim.data.first_y;
      s1_a[2] <= prim.data.first_z;
      s1_b[0] <= prim.data.second_x;
      s1_b[1] <= prim.data.second_y;
      s1_b[2] <= prim.data.second_z;
      s1_r    <= sat33($signed({2'b00, prim.data.radius}) + 33'(PAD_Q16));
      s1_t0   <= prim.data.start_t;
      s1_len  <= prim.data.use_start ? sat_sub(prim.data.end_t, prim.data.start_t)
                                     : prim.data.end_t;
      s1_us   <= prim.data.use_start;
      s1_ue   <= prim.data.use_end;
    end

    if (en[2]) begin
      s2_cmd <= s1_cmd;
      s2_us  <= s1_us;
      s2_ue  <= s1_ue;
      for (int i = 0; i < 3; i++) begin
        s2_a[i]   <= s1_a[i];
        s2_b[i]   <= s1_b[i];
        s2_pm0[i] <= 64'(s1_b[i]) * 64'(s1_t0);
        s2_pm1[i] <= 64'(s1_b[i]) * 64'(s1_len);
        s2_lo[i]  <= sat_sub(s1_a[i], s1_r);
        s2_hi[i]  <= sat_add(s1_a[i], s1_r);
      end
    end

    if (en[3]) begin
      s3_cmd <= s2_cmd;
      s3_us  <= s2_us;
      s3_ue  <= s2_ue;
      for (int i = 0; i < 3; i++) begin
        s3_a[i]  <= s2_a[i];
        s3_b[i]  <= s2_b[i];
        s3_m0[i] <= trunc_q16(s2_pm0[i]);
        s3_m1[i] <= trunc_q16(s2_pm1[i]);
        s3_lo[i] <= s2_lo[i];
        s3_hi[i] <= s2_hi[i];
      end
    end

    if (en[4]) begin
      s4_cmd <= s3_cmd;
      for (int i = 0; i < 3; i++) begin
        case (s3_cmd)
          CMD_SPHERE: begin
            s4_p1[i]   <= s3_lo[i];
            s4_step[i] <= s3_hi[i];
          end
          CMD_RAY: begin
            s4_p1[i]   <= s3_us ? sat_add(s3_a[i], s3_m0[i]) : s3_a[i];
            s4_step[i] <= s3_ue ? s3_m1[i] : s3_b[i];
          end
          default: begin
            s4_p1[i]   <= s3_a[i];
            s4_step[i] <= s3_b[i];
          end
        endcase
      end
    end

    // for non-ray kinds the step already holds the second corner
    if (en[5]) begin
      s5_cmd <= s4_cmd;
      for (int i = 0; i < 3; i++) begin
        s5_pt[0][i] <= s4_p1[i];
        s5_pt[1][i] <= (s4_cmd == CMD_RAY) ? sat_add(s4_p1[i], s4_step[i]) : s4_step[i];
      end
    end

    if (en[6]) begin
      s6_cmd <= s5_cmd;
    end
    if (en[7]) begin
      s7_cmd <= s6_cmd;
    end
    if (en[8]) begin
      s8_cmd <= s7_cmd;
    end
  end

  assign qen.diff  = en[6];
  assign qen.mul   = en[7];
  assign qen.clamp = en[8];

  for (genvar p = 0; p < 2; p++) begin : g_point
    for (genvar i = 0; i < 3; i++) begin : g_axis
      qbb_quant u_quant (
        .clk    (clk),
        .en     (qen),
        .coord  (s5_pt[p][i]),
        .center (ctr[i]),
        .scale  (scl[i]),
        .qcell  (qc[p][i])
      );
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s8_cmd == CMD_WORLD) begin
        cmin[i] = WORLD_LO;
        cmax[i] = CELL_HI;
      end else begin
        cmin[i] = (qc[0][i] < qc[1][i]) ? qc[0][i] : qc[1][i];
        cmax[i] = (qc[0][i] > qc[1][i]) ? qc[0][i] : qc[1][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES+1]) begin
      bound.data.cell_xmin <= cmin[0];
      bound.data.cell_ymin <= cmin[1];
      bound.data.cell_zmin <= cmin[2];
      bound.data.cell_xmax <= cmax[0];
      bound.data.cell_ymax <= cmax[1];
      bound.data.cell_zmax <= cmax[2];
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMP(a_min_le_max, clk, rst, bound.valid,
    (bound.data.cell_xmin <= bound.data.cell_xmax) &&
    (bound.data.cell_ymin <= bound.data.cell_ymax) &&
    (bound.data.cell_zmin <= bound.data.cell_zmax),
    "bound min exceeds max")
  `ASSERT_IMP(a_max_range, clk, rst, bound.valid,
    (bound.data.cell_xmax >= CELL_LO) && (bound.data.cell_ymax >= CELL_LO) &&
    (bound.data.cell_zmax >= CELL_LO),
    "bound max below cell range")
  `ASSERT_IMP(a_full_blocks, clk, rst, (&v) && bound.valid && !bound.ready, !prim.ready,
    "item accepted into a full pipeline")
  `ASSERT_NXT(a_last_holds, clk, rst, v[STAGES] && !en[STAGES+1], v[STAGES],
    "last stage item dropped while output stalled")

endmodule

### bench/tb_quantized_bound_box.sv
module tb_quantized_bound_box;
  import qbb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 225;

  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic [30:0] RAD_MAX = 31'h7FFF_FFFF;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam qbb_bound_t WORLD_BOX = {WORLD_LO, WORLD_LO, WORLD_LO, CELL_HI, CELL_HI, CELL_HI};
  localparam qbb_bound_t FULL_BOX = {CELL_LO, CELL_LO, CELL_LO, CELL_HI, CELL_HI, CELL_HI};
  localparam qbb_bound_t ZERO_BOX = '0;

  typedef struct {
    qbb_prim_t  prim;
    bit         known;
    qbb_bound_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  qbb_prim_if prim_ch ();
  qbb_bound_if bound_ch ();

  quantized_bound_box u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .prim      (prim_ch),
    .bound     (bound_ch)
  );

  logic [31:0] cfg_regs [6];
  qbb_bound_t pending_bounds [$];
  dir_row_t dir_rows [$];
  int errors;
  bit idle_on;
  int hold_asks;
  int hold_seen;
  int hold_left;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint clip32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Q16.16 product, toward zero, saturated
  function automatic longint fx_mul(input longint a, input longint b);
    return clip32((a * b) / 65536);
  endfunction

  function automatic longint to_cell(input longint coord, input int axis);
    longint d;
    longint q;
    d = clip32(coord - longint'(signed'(cfg_regs[REG_CENTER_X + axis])));
    q = (d * longint'(cfg_regs[REG_SCALE_X + axis])) / (longint'(1) <<< 40);
    if (q > CELL_LIMIT) q = CELL_LIMIT;
    if (q < -CELL_LIMIT) q = -CELL_LIMIT;
    return q;
  endfunction

  function automatic qbb_bound_t predict_bound(input qbb_prim_t p);
    longint lo [3];
    longint hi [3];
    longint pa [3];
    longint pb [3];
    longint org [3];
    longint vec [3];
    longint rad, t0, t1, len, ca, cb;
    org[0] = signed'(p.first_x);
    org[1] = signed'(p.first_y);
    org[2] = signed'(p.first_z);
    vec[0] = signed'(p.second_x);
    vec[1] = signed'(p.second_y);
    vec[2] = signed'(p.second_z);
    t0 = signed'(p.start_t);
    t1 = signed'(p.end_t);
    if (p.command == CMD_WORLD) begin
      for (int i = 0; i < 3; i++) begin
        lo[i] = -(CELL_LIMIT + 1);
        hi[i] = CELL_LIMIT;
      end
    end else begin
      case (p.command)
        CMD_SPHERE: begin
          rad = clip32(longint'(p.radius) + PAD_Q16);
          for (int i = 0; i < 3; i++) begin
            pa[i] = clip32(org[i] - rad);
            pb[i] = clip32(org[i] + rad);
          end
        end
        CMD_RAY: begin
          len = p.use_start ? clip32(t1 - t0) : t1;
          for (int i = 0; i < 3; i++) begin
            pa[i] = p.use_start ? clip32(org[i] + fx_mul(vec[i], t0)) : org[i];
            pb[i] = clip32(pa[i] + (p.use_end ? fx_mul(vec[i], len) : vec[i]));
          end
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            pa[i] = org[i];
            pb[i] = vec[i];
          end
        end
      endcase
      for (int i = 0; i < 3; i++) begin
        ca = to_cell(pa[i], i);
        cb = to_cell(pb[i], i);
        lo[i] = ca < cb ? ca : cb;
        hi[i] = ca > cb ? ca : cb;
      end
    end
    return {8'(lo[0]), 8'(lo[1]), 8'(lo[2]), 8'(hi[0]), 8'(hi[1]), 8'(hi[2])};
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic qbb_prim_t mk_prim(
    input cmd_t cmd,
    input logic signed [31:0] fx, input logic signed [31:0] fy, input logic signed [31:0] fz,
    input logic signed [31:0] sx, input logic signed [31:0] sy, input logic signed [31:0] sz,
    input logic [30:0] rad, input logic signed [31:0] t0, input logic signed [31:0] t1,
    input logic us, input logic ue);
    qbb_prim_t p;
    p.command = cmd;
    p.first_x = fx;
    p.first_y = fy;
    p.first_z = fz;
    p.second_x = sx;
    p.second_y = sy;
    p.second_z = sz;
    p.radius = rad;
    p.start_t = t0;
    p.end_t = t1;
    p.use_start = us;
    p.use_end = ue;
    return p;
  endfunction

  // coordinate reach that maps to 130 cells on this axis, just past the cell limit
  function automatic longint axis_span(input int axis);
    longint s;
    if (cfg_regs[REG_SCALE_X + axis] == 0) return S32_MAX;
    s = (longint'(130) <<< 40) / longint'(cfg_regs[REG_SCALE_X + axis]);
    if (s > S32_MAX) s = S32_MAX;
    if (s < 1) s = 1;
    return s;
  endfunction

  function automatic longint rand_in(input longint s);
    return (longint'($urandom) % (2 * s + 1)) - s;
  endfunction

  function automatic logic signed [31:0] pick_edge();
    case ($urandom_range(0, 3))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord(input int axis);
    longint s;
    s = axis_span(axis);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return pick_edge();
      default: return 32'(clip32(longint'(signed'(cfg_regs[REG_CENTER_X + axis])) + rand_in(s)));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_dir(input int axis);
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return pick_edge();
      default: return 32'(rand_in(axis_span(axis) / 2 + 1));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_param();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return pick_edge();
      default: return 32'(rand_in(3 * 65536));
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 7))
      0: return 31'($urandom);
      1: return $urandom_range(0, 1) ? RAD_MAX : 31'd0;
      default: return 31'(longint'($urandom) % (axis_span($urandom_range(0, 2)) + 1));
    endcase
  endfunction

  function automatic qbb_prim_t rand_prim();
    qbb_prim_t p;
    int sel;
    sel = $urandom_range(0, 9);
    p.command = sel == 0 ? CMD_WORLD : sel < 4 ? CMD_BOX : sel < 7 ? CMD_SPHERE : CMD_RAY;
    p.first_x = rand_coord(0);
    p.first_y = rand_coord(1);
    p.first_z = rand_coord(2);
    if (p.command == CMD_RAY) begin
      p.second_x = rand_dir(0);
      p.second_y = rand_dir(1);
      p.second_z = rand_dir(2);
    end else begin
      p.second_x = rand_coord(0);
      p.second_y = rand_coord(1);
      p.second_z = rand_coord(2);
    end
    p.radius = rand_radius();
    p.start_t = rand_param();
    p.end_t = rand_param();
    p.use_start = 1'($urandom_range(0, 1));
    p.use_end = 1'($urandom_range(0, 1));
    return p;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_prim(input qbb_prim_t p, input qbb_bound_t want);
    if (idle_on && $urandom_range(0, 99) < 29) begin
      prim_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    prim_ch.valid <= 1'b1;
    prim_ch.data <= p;
    do @(posedge clk); while (!prim_ch.ready);
    pending_bounds.push_back(want);
  endtask

  task automatic settle();
    prim_ch.valid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (STAGES + 2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx <= REG_SCALE_Z) cfg_regs[idx] = val;
  endtask

  task automatic load_phase(input int phase);
    logic [31:0] v [6];
    case (phase)
      1: begin
        for (int i = 0; i < 3; i++) begin
          v[REG_CENTER_X + i] = 32'(rand_in(1 << 20));
          v[REG_SCALE_X + i] = $urandom_range(32'h0080_0000, 32'h0800_0000);
        end
      end
      2: begin
        for (int i = 0; i < 3; i++) begin
          v[REG_CENTER_X + i] = Q_MIN;
          v[REG_SCALE_X + i] = 32'hFFFF_FFFF;
        end
      end
      3: begin
        for (int i = 0; i < 3; i++) v[REG_CENTER_X + i] = Q_MAX;
        v[REG_SCALE_X] = 32'd0;
        v[REG_SCALE_Y] = 32'd1;
        v[REG_SCALE_Z] = 32'hFFFF_FFFF;
      end
      4: begin
        v[REG_CENTER_X] = 32'd0;
        v[REG_CENTER_Y] = 32'hFFFF_FFFF;
        v[REG_CENTER_Z] = CENTER_RST;
        v[REG_SCALE_X] = 32'h0100_0000;
        v[REG_SCALE_Y] = SCALE_RST;
        v[REG_SCALE_Z] = 32'h8000_0000;
      end
      5: begin
        for (int i = 0; i < 6; i++) v[i] = $urandom;
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          v[REG_CENTER_X + i] = CENTER_RST;
          v[REG_SCALE_X + i] = SCALE_RST;
        end
        v[REG_CENTER_Z] = 32'(rand_in(1 << 16));
      end
    endcase
    for (int i = 0; i < 6; i++) cfg_write(CFG_IDX_W'(i), v[i]);
    // unmapped index must leave every register alone
    cfg_write(phase[0] ? REG_SPARE_A : REG_SPARE_B, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking
  task automatic cmp_cell(input string name, input logic signed [7:0] want,
                          input logic signed [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_bound(input qbb_bound_t got);
    qbb_bound_t want;
    if (pending_bounds.size() == 0) begin
      $display("%0t: bound with no item pending, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_bounds.pop_front();
    cmp_cell("cell_xmin", want.cell_xmin, got.cell_xmin);
    cmp_cell("cell_ymin", want.cell_ymin, got.cell_ymin);
    cmp_cell("cell_zmin", want.cell_zmin, got.cell_zmin);
    cmp_cell("cell_xmax", want.cell_xmax, got.cell_xmax);
    cmp_cell("cell_ymax", want.cell_ymax, got.cell_ymax);
    cmp_cell("cell_zmax", want.cell_zmax, got.cell_zmax);
  endtask

  // output side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst && bound_ch.valid && bound_ch.ready) check_bound(bound_ch.data);
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      bound_ch.ready <= 1'b0;
    end else begin
      bound_ch.ready <= !(idle_on && $urandom_range(0, 99) < 29);
    end
  end

  always @(posedge clk) begin
    if ((prim_ch.valid && prim_ch.ready) || (bound_ch.valid && bound_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("quantized_bound_box test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    qbb_prim_t item;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    prim_ch.valid = 1'b0;
    prim_ch.data = '0;
    bound_ch.ready = 1'b0;
    errors = 0;
    idle_on = 1'b1;
    hold_asks = 0;
    hold_seen = 0;
    hold_left = 0;
    stall_cycles = 0;
    for (int i = 0; i < 3; i++) begin
      cfg_regs[REG_CENTER_X + i] = CENTER_RST;
      cfg_regs[REG_SCALE_X + i] = SCALE_RST;
    end

    // whole world, extremes, padding, ray flag combinations, saturation
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_WORLD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b1, WORLD_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_WORLD, -1, -1, -1, -1, -1, -1, RAD_MAX,
                                          -1, -1, 1, 1), 1'b1, WORLD_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_BOX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX,
                                          0, 0, 0, 0, 0), 1'b1, FULL_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_BOX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN,
                                          RAD_MAX, Q_MAX, Q_MIN, 1, 1), 1'b1, FULL_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b1, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_SPHERE, 0, 0, 0, Q_MIN, Q_MAX, -1, RAD_MAX,
                                          0, 0, 0, 0), 1'b1, FULL_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_BOX, 258, 258, 258, 775, -259, 1258,
                                          0, 0, 0, 0, 0), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_BOX, -Q_ONE, Q_ONE / 2, -Q_ONE / 3,
                                          Q_ONE, -Q_ONE / 2, 7, 0, 0, 0, 0, 0), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_SPHERE, Q_MAX, Q_MIN, 258, 0, 0, 0, 100,
                                          0, 0, 0, 0), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_SPHERE, Q_MIN, Q_MAX, -Q_ONE / 4, 0, 0, 0,
                                          31'(Q_ONE / 8), 0, 0, 0, 0), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_RAY, 0, 0, 0, Q_ONE / 2, -Q_ONE / 4, Q_MAX,
                                          0, Q_MAX, Q_MIN, 0, 0), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_RAY, -Q_ONE / 2, 0, 0, Q_ONE / 4, Q_ONE / 4,
                                          -Q_ONE / 4, 0, Q_ONE / 2, 0, 1, 0), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_RAY, 0, -Q_ONE / 2, 0, Q_ONE / 4, Q_ONE / 4,
                                          -Q_ONE / 4, 0, 0, 2 * Q_ONE, 0, 1), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_RAY, 0, 0, Q_ONE / 3, Q_ONE / 4, -Q_ONE / 5,
                                          Q_ONE / 6, 0, -3 * Q_ONE / 2, 3 * Q_ONE / 4, 1, 1),
                                  1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_RAY, 0, 0, 0, Q_MAX, Q_MIN, 1, 0,
                                          Q_MIN, Q_MAX, 1, 1), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_RAY, 258, 258, 258, -3, 3, -1, 0,
                                          0, 1, 0, 1), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_RAY, Q_MIN, Q_MAX, 0, Q_MAX, Q_MIN, Q_MAX, 0,
                                          0, Q_MAX, 0, 1), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_RAY, 0, 0, 0, -Q_ONE, Q_ONE, 0, 0,
                                          Q_MIN, 0, 1, 0), 1'b0, ZERO_BOX});
    dir_rows.push_back(dir_row_t'{mk_prim(CMD_BOX, Q_MIN, 0, Q_MAX, 258, Q_MIN, -1,
                                          0, 0, 0, 0, 0), 1'b0, ZERO_BOX});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_prim(dir_rows[i].prim,
                dir_rows[i].known ? dir_rows[i].want : predict_bound(dir_rows[i].prim));
    end
    settle();

    for (int phase = 1; phase <= PHASES; phase++) begin
      load_phase(phase);
      idle_on <= (phase != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 30) hold_asks <= hold_asks + 1;
        item = rand_prim();
        send_prim(item, predict_bound(item));
      end
      settle();
    end

    if (errors == 0) begin
      $display("quantized_bound_box test passed");
    end else begin
      $display("quantized_bound_box test failed");
    end
    $finish;
  end

endmodule
